@@ rtl/cei_pkg.sv @@
// Shared types, constants and tables for the elliptic integral block.
// Used by cei_dp, cei_ctrl and the top level.
package cei_pkg;

   localparam int MAX_ITER = 8;
   localparam int ITER_W   = $clog2(MAX_ITER + 1);
   localparam int TOL_W    = 8;
   localparam int EK_W     = 48;
   localparam int S_W      = 36;

   localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
   localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [31:0] PI_HALF_Q26 = 32'd105414357;
   localparam logic [31:0] ONE_Q26     = 32'd67108864;
   localparam logic [31:0] RES_MAX     = 32'hFFFF_FFFF;
   localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
   localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

   localparam logic [1:0] FORM_PARAM = 2'd1;
   localparam logic [1:0] FORM_ANGLE = 2'd2;

   localparam logic ACT_K = 1'b0;

   localparam logic [1:0] STAT_VALID  = 2'd0;
   localparam logic [1:0] STAT_INF    = 2'd1;
   localparam logic [1:0] STAT_DOMAIN = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DECODE, OP_SIN_SQ, OP_SIN_X2, OP_SIN_MUL, OP_SIN_DIV,
      OP_SIN_FIX, OP_SIN_ACC, OP_K_SQ, OP_K_DEC, OP_PARAM, OP_G0_SQRT, OP_G0_SET,
      OP_ITER_PROD, OP_ITER_SQRT, OP_ITER_UPD, OP_FIN_MUL, OP_FIN_DIV, OP_FIN_RES,
      OP_SPECIAL, OP_EMIT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_SIN_SQ, ST_SIN_X2, ST_SIN_MUL, ST_SIN_DIV_GO,
      ST_SIN_DIV_WAIT, ST_SIN_ACC, ST_K_SQ, ST_K_DEC, ST_PARAM, ST_CLASSIFY,
      ST_G0_GO, ST_G0_WAIT, ST_ITER_PROD, ST_ITER_GO, ST_ITER_WAIT, ST_ITER_UPD,
      ST_FIN_MUL, ST_FIN_GO, ST_FIN_WAIT, ST_FIN_RES, ST_SPECIAL, ST_OUT
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic       zero;
      logic [1:0] form;
      logic       action;
      logic       err;
      logic       unity;
      logic       sqrt_done;
      logic       div_done;
      logic       conv;
      logic       last_iter;
      logic       sin_last;
      logic       out_free;
   } stat_type;

   function automatic logic [7:0] sine_divisor(input logic [2:0] idx);
      logic [7:0] d;
      case (idx)
         3'd1: d = 8'd6;
         3'd2: d = 8'd20;
         3'd3: d = 8'd42;
         3'd4: d = 8'd72;
         3'd5: d = 8'd110;
         3'd6: d = 8'd156;
         3'd7: d = 8'd210;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

   // floor(2^32 / divisor), one low estimate step at most
   function automatic logic [31:0] sine_recip(input logic [2:0] idx);
      logic [31:0] r;
      case (idx)
         3'd1: r = 32'd715827882;
         3'd2: r = 32'd214748364;
         3'd3: r = 32'd102261126;
         3'd4: r = 32'd59652323;
         3'd5: r = 32'd39045157;
         3'd6: r = 32'd27531841;
         3'd7: r = 32'd20452225;
         default: r = 32'hFFFF_FFFF;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/cei_sqrt.sv @@
// Bit-serial floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on nothing but the clock and reset.
module cei_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [31:0] root
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [64:0] trial;

   always_comb begin
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = operand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[63:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule

@@ rtl/cei_div.sv @@
// Restoring 64-bit by 64-bit unsigned divider, one quotient bit per cycle.
// Depends on nothing but the clock and reset.
module cei_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] shifted;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, num_ff[63]};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 64'(shifted - {1'b0, den_ff}) : shifted[63:0];
         num_in = {num_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;
endmodule

@@ rtl/cei_dp.sv @@
// Datapath: argument decode, sine series, mean iteration, final divide, result beat.
// Depends on cei_pkg, cei_sqrt and cei_div; driven by commands from cei_ctrl.
module cei_dp (
   input  logic              clock,
   input  logic              reset,
   input  cei_pkg::cmd_type  cmd,
   output cei_pkg::stat_type stat,
   input  logic              csr_wren,
   input  logic [7:0]        csr_wdata,
   input  logic [31:0]       req_tdata,
   input  logic [2:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser
);
   localparam logic [cei_pkg::ITER_W-1:0] ITER_ONE = cei_pkg::ITER_W'(1);

   logic [cei_pkg::TOL_W-1:0]  tol_ff, tol_in;
   logic                       action_ff, action_in;
   logic [1:0]                 form_ff, form_in;
   logic [31:0]                v_ff, v_in;
   logic [31:0]                x_ff, x_in;
   logic [31:0]                x2_ff, x2_in;
   logic [31:0]                term_ff, term_in;
   logic signed [cei_pkg::S_W-1:0]  s_ff, s_in;
   logic [2:0]                 sidx_ff, sidx_in;
   logic [63:0]                prod_ff, prod_in;
   logic [63:0]                om_ff, om_in;
   logic signed [cei_pkg::EK_W-1:0] ek_ff, ek_in;
   logic [31:0]                a_ff, a_in, g_ff, g_in, ad_ff, ad_in, anx_ff, anx_in;
   logic [cei_pkg::ITER_W-1:0] n_ff, n_in;
   logic                       err_ff, err_in, unity_ff, unity_in;
   logic [31:0]                resv_ff, resv_in;
   logic [1:0]                 ress_ff, ress_in;
   logic                       ovalid_ff, ovalid_in;
   logic [31:0]                odata_ff, odata_in;
   logic [1:0]                 ouser_ff, ouser_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [7:0]  sdiv;
   logic [39:0] q_prod, q_rem;
   logic [31:0] q_fix;
   logic [31:0] v_abs;
   logic signed [34:0] v_sx, ek_p;
   logic [33:0] om_p;
   logic signed [cei_pkg::S_W-1:0] s_new;
   logic signed [cei_pkg::EK_W-1:0] ek_k, ek_sub, ekc;
   logic [32:0] dif, sum;
   logic        sq_start, sq_done, dv_start, dv_done;
   logic [63:0] sq_op, dv_num, dv_den, quot;
   logic [31:0] root;
   logic        out_free;

   cei_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_op),
      .done    (sq_done),
      .root    (root)
   );

   cei_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_num),
      .divisor  (dv_den),
      .done     (dv_done),
      .quotient (quot)
   );

   always_comb begin
      out_free = !ovalid_ff || rsp_tready;
      v_abs    = v_ff[31] ? (~v_ff + 32'd1) : v_ff;
      v_sx     = {{3{v_ff[31]}}, v_ff};
      ek_p     = 35'sh0_8000_0000 - v_sx;
      om_p     = 34'h0_4000_0000 - v_sx[33:0];
      ek_k     = $signed({14'b0, 34'h0_8000_0000}) - $signed({14'b0, prod_ff[63:30]});
      ek_sub   = $signed(48'(prod_ff[63:32]) << n_ff);
      ekc      = ek_ff[cei_pkg::EK_W-1] ? '0 : ek_ff;
      dif      = {1'b0, a_ff} - {1'b0, g_ff};
      sum      = {1'b0, a_ff} + {1'b0, g_ff};
      sdiv     = cei_pkg::sine_divisor(sidx_ff);
      q_prod   = 40'(prod_ff[63:32]) * 40'(sdiv);
      q_rem    = 40'(term_ff) - q_prod;
      q_fix    = (q_rem >= 40'(sdiv)) ? (prod_ff[63:32] + 32'd1) : prod_ff[63:32];
      s_new    = sidx_ff[0] ? (s_ff - $signed({4'b0, term_ff}))
                            : (s_ff + $signed({4'b0, term_ff}));

      mul_a = x_ff;
      mul_b = x_ff;
      case (cmd.op)
         cei_pkg::OP_SIN_MUL: begin
            mul_a = term_ff;
            mul_b = x2_ff;
         end
         cei_pkg::OP_SIN_DIV: begin
            mul_a = prod_ff[61:30];
            mul_b = cei_pkg::sine_recip(sidx_ff);
         end
         cei_pkg::OP_ITER_PROD: begin
            mul_a = a_ff;
            mul_b = g_ff;
         end
         cei_pkg::OP_ITER_SQRT: begin
            mul_a = ad_ff;
            mul_b = ad_ff;
         end
         cei_pkg::OP_FIN_MUL: begin
            mul_a = cei_pkg::PI_HALF_Q30;
            mul_b = ekc[31:0];
         end
         default: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
      endcase
      mul_p = {32'b0, mul_a} * {32'b0, mul_b};

      sq_start = (cmd.op == cei_pkg::OP_G0_SQRT) || (cmd.op == cei_pkg::OP_ITER_SQRT);
      sq_op    = (cmd.op == cei_pkg::OP_G0_SQRT) ? om_ff : prod_ff;
      dv_start = cmd.op == cei_pkg::OP_FIN_DIV;
      if (action_ff == cei_pkg::ACT_K) begin
         dv_num = 64'(cei_pkg::PI_HALF_Q30) << 26;
         dv_den = (g_ff == '0) ? 64'd1 : 64'(g_ff);
      end else begin
         dv_num = prod_ff;
         dv_den = ((a_ff == '0) ? 64'd1 : 64'(a_ff)) << 5;
      end
   end

   always_comb begin
      tol_in    = csr_wren ? csr_wdata : tol_ff;
      action_in = action_ff;
      form_in   = form_ff;
      v_in      = v_ff;
      x_in      = x_ff;
      x2_in     = x2_ff;
      term_in   = term_ff;
      s_in      = s_ff;
      sidx_in   = sidx_ff;
      prod_in   = prod_ff;
      om_in     = om_ff;
      ek_in     = ek_ff;
      a_in      = a_ff;
      g_in      = g_ff;
      ad_in     = ad_ff;
      anx_in    = anx_ff;
      n_in      = n_ff;
      err_in    = err_ff;
      unity_in  = unity_ff;
      resv_in   = resv_ff;
      ress_in   = ress_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      ouser_in  = ouser_ff;
      case (cmd.op)
         cei_pkg::OP_LOAD: begin
            action_in = req_tuser[0];
            form_in   = req_tuser[2:1];
            v_in      = req_tdata;
            err_in    = 1'b0;
            unity_in  = 1'b0;
         end
         cei_pkg::OP_DECODE: begin
            x_in = (form_ff == cei_pkg::FORM_ANGLE && v_abs > cei_pkg::PI_HALF_Q30)
                   ? (cei_pkg::PI_Q30 - v_abs) : v_abs;
         end
         cei_pkg::OP_SIN_SQ: begin
            prod_in = mul_p;
            term_in = x_ff;
            s_in    = $signed({4'b0, x_ff});
            sidx_in = 3'd1;
         end
         cei_pkg::OP_SIN_X2: x2_in = prod_ff[61:30];
         cei_pkg::OP_SIN_MUL: prod_in = mul_p;
         cei_pkg::OP_SIN_DIV: begin
            term_in = prod_ff[61:30];
            prod_in = mul_p;
         end
         cei_pkg::OP_SIN_FIX: term_in = q_fix;
         cei_pkg::OP_SIN_ACC: begin
            s_in    = s_new;
            sidx_in = sidx_ff + 3'd1;
            if (s_new < 0) begin
               x_in = '0;
            end else if (s_new > $signed({4'b0, cei_pkg::ONE_Q30})) begin
               x_in = cei_pkg::ONE_Q30;
            end else begin
               x_in = s_new[31:0];
            end
         end
         cei_pkg::OP_K_SQ: prod_in = mul_p;
         cei_pkg::OP_K_DEC: begin
            err_in   = prod_ff > cei_pkg::ONE_Q60;
            unity_in = prod_ff == cei_pkg::ONE_Q60;
            om_in    = cei_pkg::ONE_Q60 - prod_ff;
            ek_in    = ek_k;
         end
         cei_pkg::OP_PARAM: begin
            err_in   = $signed(v_ff) > $signed(cei_pkg::ONE_Q30);
            unity_in = v_ff == cei_pkg::ONE_Q30;
            om_in    = 64'(om_p[31:0]) << 30;
            ek_in    = {{13{ek_p[34]}}, ek_p};
         end
         cei_pkg::OP_G0_SET: begin
            a_in = cei_pkg::ONE_Q30;
            g_in = root;
            n_in = ITER_ONE;
         end
         cei_pkg::OP_ITER_PROD: begin
            prod_in = mul_p;
            ad_in   = dif[32] ? (~dif[31:0] + 32'd1) : dif[31:0];
            anx_in  = sum[32:1];
         end
         cei_pkg::OP_ITER_SQRT: prod_in = mul_p;
         cei_pkg::OP_ITER_UPD: begin
            g_in  = root;
            a_in  = anx_ff;
            ek_in = ek_ff - ek_sub;
            n_in  = n_ff + ITER_ONE;
         end
         cei_pkg::OP_FIN_MUL: begin
            prod_in = mul_p
                    + (ekc[32] ? (64'(cei_pkg::PI_HALF_Q30) << 32) : 64'd0);
         end
         cei_pkg::OP_FIN_RES: begin
            resv_in = (quot[63:32] != '0) ? cei_pkg::RES_MAX : quot[31:0];
            ress_in = cei_pkg::STAT_VALID;
         end
         cei_pkg::OP_SPECIAL: begin
            if (v_ff == '0) begin
               resv_in = cei_pkg::PI_HALF_Q26;
               ress_in = cei_pkg::STAT_VALID;
            end else if (err_ff) begin
               resv_in = '0;
               ress_in = cei_pkg::STAT_DOMAIN;
            end else if (action_ff == cei_pkg::ACT_K) begin
               resv_in = cei_pkg::RES_MAX;
               ress_in = cei_pkg::STAT_INF;
            end else begin
               resv_in = cei_pkg::ONE_Q26;
               ress_in = cei_pkg::STAT_VALID;
            end
         end
         cei_pkg::OP_EMIT: begin
            ovalid_in = 1'b1;
            odata_in  = resv_ff;
            ouser_in  = ress_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= cei_pkg::TOL_RESET;
         ovalid_ff <= 1'b0;
      end else begin
         tol_ff    <= tol_in;
         ovalid_ff <= ovalid_in;
      end
      action_ff <= action_in;
      form_ff   <= form_in;
      v_ff      <= v_in;
      x_ff      <= x_in;
      x2_ff     <= x2_in;
      term_ff   <= term_in;
      s_ff      <= s_in;
      sidx_ff   <= sidx_in;
      prod_ff   <= prod_in;
      om_ff     <= om_in;
      ek_ff     <= ek_in;
      a_ff      <= a_in;
      g_ff      <= g_in;
      ad_ff     <= ad_in;
      anx_ff    <= anx_in;
      n_ff      <= n_in;
      err_ff    <= err_in;
      unity_ff  <= unity_in;
      resv_ff   <= resv_in;
      ress_ff   <= ress_in;
      odata_ff  <= odata_in;
      ouser_ff  <= ouser_in;
   end

   always_comb begin
      stat.zero      = v_ff == '0;
      stat.form      = form_ff;
      stat.action    = action_ff;
      stat.err       = err_ff;
      stat.unity     = unity_ff;
      stat.sqrt_done = sq_done;
      stat.div_done  = dv_done;
      stat.conv      = ad_ff <= 32'(tol_ff);
      stat.last_iter = n_ff == cei_pkg::ITER_W'(cei_pkg::MAX_ITER);
      stat.sin_last  = sidx_ff == 3'd7;
      stat.out_free  = out_free;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
endmodule

@@ rtl/cei_ctrl.sv @@
// Sequencer for the elliptic integral datapath: one item at a time.
// Depends on cei_pkg; issues commands to cei_dp and reads its status.
module cei_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              in_ready,
   input  cei_pkg::stat_type stat,
   output cei_pkg::cmd_type  cmd
);
   cei_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cei_pkg::ST_IDLE: if (req_tvalid) state_in = cei_pkg::ST_DECODE;
         cei_pkg::ST_DECODE: begin
            if (stat.zero) state_in = cei_pkg::ST_SPECIAL;
            else if (stat.form == cei_pkg::FORM_PARAM) state_in = cei_pkg::ST_PARAM;
            else if (stat.form == cei_pkg::FORM_ANGLE) state_in = cei_pkg::ST_SIN_SQ;
            else state_in = cei_pkg::ST_K_SQ;
         end
         cei_pkg::ST_SIN_SQ:     state_in = cei_pkg::ST_SIN_X2;
         cei_pkg::ST_SIN_X2:     state_in = cei_pkg::ST_SIN_MUL;
         cei_pkg::ST_SIN_MUL:    state_in = cei_pkg::ST_SIN_DIV_GO;
         cei_pkg::ST_SIN_DIV_GO: state_in = cei_pkg::ST_SIN_DIV_WAIT;
         cei_pkg::ST_SIN_DIV_WAIT: state_in = cei_pkg::ST_SIN_ACC;
         cei_pkg::ST_SIN_ACC:
            state_in = stat.sin_last ? cei_pkg::ST_K_SQ : cei_pkg::ST_SIN_MUL;
         cei_pkg::ST_K_SQ:       state_in = cei_pkg::ST_K_DEC;
         cei_pkg::ST_K_DEC:      state_in = cei_pkg::ST_CLASSIFY;
         cei_pkg::ST_PARAM:      state_in = cei_pkg::ST_CLASSIFY;
         cei_pkg::ST_CLASSIFY:
            state_in = (stat.err || stat.unity) ? cei_pkg::ST_SPECIAL : cei_pkg::ST_G0_GO;
         cei_pkg::ST_G0_GO:      state_in = cei_pkg::ST_G0_WAIT;
         cei_pkg::ST_G0_WAIT:    if (stat.sqrt_done) state_in = cei_pkg::ST_ITER_PROD;
         cei_pkg::ST_ITER_PROD:  state_in = cei_pkg::ST_ITER_GO;
         cei_pkg::ST_ITER_GO:    state_in = cei_pkg::ST_ITER_WAIT;
         cei_pkg::ST_ITER_WAIT:  if (stat.sqrt_done) state_in = cei_pkg::ST_ITER_UPD;
         cei_pkg::ST_ITER_UPD: begin
            if (stat.conv || stat.last_iter) begin
               state_in = (stat.action == cei_pkg::ACT_K) ? cei_pkg::ST_FIN_GO
                                                          : cei_pkg::ST_FIN_MUL;
            end else begin
               state_in = cei_pkg::ST_ITER_PROD;
            end
         end
         cei_pkg::ST_FIN_MUL:    state_in = cei_pkg::ST_FIN_GO;
         cei_pkg::ST_FIN_GO:     state_in = cei_pkg::ST_FIN_WAIT;
         cei_pkg::ST_FIN_WAIT:   if (stat.div_done) state_in = cei_pkg::ST_FIN_RES;
         cei_pkg::ST_FIN_RES:    state_in = cei_pkg::ST_OUT;
         cei_pkg::ST_SPECIAL:    state_in = cei_pkg::ST_OUT;
         cei_pkg::ST_OUT:        if (stat.out_free) state_in = cei_pkg::ST_IDLE;
         default:                state_in = cei_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready = 1'b0;
      cmd.op   = cei_pkg::OP_NONE;
      case (state_ff)
         cei_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (req_tvalid) cmd.op = cei_pkg::OP_LOAD;
         end
         cei_pkg::ST_DECODE:     cmd.op = cei_pkg::OP_DECODE;
         cei_pkg::ST_SIN_SQ:     cmd.op = cei_pkg::OP_SIN_SQ;
         cei_pkg::ST_SIN_X2:     cmd.op = cei_pkg::OP_SIN_X2;
         cei_pkg::ST_SIN_MUL:    cmd.op = cei_pkg::OP_SIN_MUL;
         cei_pkg::ST_SIN_DIV_GO: cmd.op = cei_pkg::OP_SIN_DIV;
         cei_pkg::ST_SIN_DIV_WAIT: cmd.op = cei_pkg::OP_SIN_FIX;
         cei_pkg::ST_SIN_ACC:    cmd.op = cei_pkg::OP_SIN_ACC;
         cei_pkg::ST_K_SQ:       cmd.op = cei_pkg::OP_K_SQ;
         cei_pkg::ST_K_DEC:      cmd.op = cei_pkg::OP_K_DEC;
         cei_pkg::ST_PARAM:      cmd.op = cei_pkg::OP_PARAM;
         cei_pkg::ST_G0_GO:      cmd.op = cei_pkg::OP_G0_SQRT;
         cei_pkg::ST_G0_WAIT:    if (stat.sqrt_done) cmd.op = cei_pkg::OP_G0_SET;
         cei_pkg::ST_ITER_PROD:  cmd.op = cei_pkg::OP_ITER_PROD;
         cei_pkg::ST_ITER_GO:    cmd.op = cei_pkg::OP_ITER_SQRT;
         cei_pkg::ST_ITER_UPD:   cmd.op = cei_pkg::OP_ITER_UPD;
         cei_pkg::ST_FIN_MUL:    cmd.op = cei_pkg::OP_FIN_MUL;
         cei_pkg::ST_FIN_GO:     cmd.op = cei_pkg::OP_FIN_DIV;
         cei_pkg::ST_FIN_RES:    cmd.op = cei_pkg::OP_FIN_RES;
         cei_pkg::ST_SPECIAL:    cmd.op = cei_pkg::OP_SPECIAL;
         cei_pkg::ST_OUT:        if (stat.out_free) cmd.op = cei_pkg::OP_EMIT;
         default:                cmd.op = cei_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= cei_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

@@ rtl/complete_elliptic_integral_agm.sv @@
// Top level: complete elliptic integrals K and E by the arithmetic-geometric mean.
// Depends on cei_pkg, cei_ctrl and cei_dp (which holds cei_sqrt and cei_div).
//
//   channel | direction | payload
//   req     | in        | tdata argument_value Q2.30; tuser action, argument_form
//   rsp     | out       | tdata integral_value Q6.26; tuser result_status
//   csr     | in        | wdata convergence_tolerance
//
// One item at a time. Zero argument, domain error and unit parameter skip the mean
// iteration and take the special-case path. A normal item runs the mean steps and the
// final divide; the angle form adds the sine series. The 64-step divider and the
// 32-step square root set most of the run time. Reset is synchronous and clears
// control state; the tolerance returns to 1. A stalled result beat is held in the
// output register while the next item is taken.
module complete_elliptic_integral_agm (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wren,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] argument_value
   input  logic [2:0]  req_tuser,   // [0] action, [2:1] argument_form
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] integral_value
   output logic [1:0]  rsp_tuser    // [1:0] result_status
);
   cei_pkg::cmd_type  cmd;
   cei_pkg::stat_type stat;

   cei_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .in_ready   (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cei_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wren   (csr_wren),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef ASSERT_OFF
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined result status");

   a_inf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == cei_pkg::STAT_INF |-> rsp_tdata == cei_pkg::RES_MAX)
      else $error("infinite result not saturated");
`endif
endmodule
